>>> rtl/core/vic_pkg.sv
package vic_pkg;

	localparam int IDX_W   = 12;
	localparam int CNT_W   = 13;
	localparam int EPOCH_W = 8;

	localparam logic CMD_GROUP  = 1'b0;
	localparam logic CMD_CORNER = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} vic_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a corner and read the three maps
		logic commit;    // update the maps and load the output register
		logic new_group; // advance the group epoch and zero the counters
		logic clear_en;  // write one entry of the clearing sweep
	} vic_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic epoch_last; // the epoch is at its last value; the next group needs a sweep
		logic clear_done; // the sweep writes its last entry in this cycle
		logic out_free;   // the output register can take a result in this cycle
	} vic_stat_t;

	typedef struct packed {
		logic [IDX_W-1:0] dense;
		logic             first;
		logic [IDX_W-1:0] source;
	} vic_attr_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [IDX_W-1:0]   dense;
	} vic_entry_t;

endpackage

>>> rtl/core/vertex_index_compactor.sv
// A face corner transfer captures the three map reads; its result is committed into the output
// register once the output is free, and the map write-back happens at that commit. The block
// takes no new item while a corner lookup is pending; a start-group transfer needs no lookup.
// Every 255th start-group, and once after reset, a clearing pass writes every map entry, one
// per cycle (min(INDEX_COUNT, 4096) entries, 4096 by default) with in_ready low meanwhile.
// Reset is asynchronous and active low; it clears control state and counters and sets the epoch to one.
module vertex_index_compactor #(
	parameter int INDEX_COUNT = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic [vic_pkg::IDX_W-1:0] position_index,
	input  logic [vic_pkg::IDX_W-1:0] normal_index,
	input  logic [vic_pkg::IDX_W-1:0] texcoord_index,
	input  logic                      has_normal,
	input  logic                      has_texcoord,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [vic_pkg::IDX_W-1:0] dense_position,
	output logic                      position_first,
	output logic [vic_pkg::IDX_W-1:0] source_position,
	output logic [vic_pkg::IDX_W-1:0] dense_normal,
	output logic                      normal_first,
	output logic [vic_pkg::IDX_W-1:0] source_normal,
	output logic [vic_pkg::IDX_W-1:0] dense_texcoord,
	output logic                      texcoord_first,
	output logic [vic_pkg::IDX_W-1:0] source_texcoord
);

	// Each map entry holds a dense index and the epoch of the group that wrote it. A lookup
	// counts as a hit only when the stored epoch equals the current one, so starting a group
	// is just an epoch increment. Swept entries carry epoch zero, which no live group uses;
	// when the epoch runs out, the controller runs the clearing pass and restarts at one.

	vic_pkg::vic_cmd_t  cmd;
	vic_pkg::vic_stat_t stat;
	vic_pkg::vic_attr_t res_pos, res_nrm, res_tex;

	vic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// The datapath holds the three maps, their counters and the output register. The
	// output register lets a new corner transfer in while the previous result still waits.
	vic_datapath #(.INDEX_COUNT(INDEX_COUNT)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.position_index (position_index),
		.normal_index   (normal_index),
		.texcoord_index (texcoord_index),
		.has_normal     (has_normal),
		.has_texcoord   (has_texcoord),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.out_position   (res_pos),
		.out_normal     (res_nrm),
		.out_texcoord   (res_tex)
	);

	assign dense_position  = res_pos.dense;
	assign position_first  = res_pos.first;
	assign source_position = res_pos.source;
	assign dense_normal    = res_nrm.dense;
	assign normal_first    = res_nrm.first;
	assign source_normal   = res_nrm.source;
	assign dense_texcoord  = res_tex.dense;
	assign texcoord_first  = res_tex.first;
	assign source_texcoord = res_tex.source;

`ifndef SYNTH
	// A corner arriving at an empty output shows its result once the lookup state commits it.
	a_corner_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == vic_pkg::CMD_CORNER && !out_valid)
		|=> ##1 out_valid)
		else $error("corner transfer did not produce a result");

	// A start-group transfer never produces a result.
	a_group_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == vic_pkg::CMD_GROUP && !out_valid)
		|=> !out_valid)
		else $error("start-group transfer produced a result");

	// The block works on one corner at a time.
	a_one_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == vic_pkg::CMD_CORNER) |=> !in_ready)
		else $error("input taken while a corner lookup is pending");
`endif

endmodule

>>> rtl/core/vic_ctrl.sv
module vic_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              command,
	input  vic_pkg::vic_stat_t stat,
	output logic              in_ready,
	output vic_pkg::vic_cmd_t  cmd
);

	vic_pkg::vic_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vic_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vic_pkg::ST_CLEAR: begin
				if (stat.clear_done) state_d = vic_pkg::ST_IDLE;
			end
			vic_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (command == vic_pkg::CMD_CORNER) begin
						state_d = vic_pkg::ST_LOOKUP;
					end else if (stat.epoch_last) begin
						state_d = vic_pkg::ST_CLEAR;
					end
				end
			end
			vic_pkg::ST_LOOKUP: begin
				if (stat.out_free) state_d = vic_pkg::ST_IDLE;
			end
			default: state_d = vic_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			vic_pkg::ST_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			vic_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load      = in_valid && (command == vic_pkg::CMD_CORNER);
				cmd.new_group = in_valid && (command == vic_pkg::CMD_GROUP);
			end
			vic_pkg::ST_LOOKUP: begin
				cmd.commit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/vic_remap.sv
module vic_remap #(
	parameter int INDEX_COUNT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vic_pkg::vic_cmd_t             cmd,
	input  logic [vic_pkg::EPOCH_W-1:0]   epoch,
	input  logic [$clog2((INDEX_COUNT > 4096) ? 4096 : INDEX_COUNT)-1:0] clear_addr,
	input  logic [vic_pkg::IDX_W-1:0]     src_index,
	input  logic                          present,
	output vic_pkg::vic_attr_t            result
);

	localparam int  DEPTH  = (INDEX_COUNT > 4096) ? 4096 : INDEX_COUNT;
	localparam int  AW     = $clog2(DEPTH);
	localparam bit  ALL_IN = INDEX_COUNT >= 4096;

	vic_pkg::vic_entry_t             mem_q [DEPTH];
	vic_pkg::vic_entry_t             rd_q;
	logic [vic_pkg::IDX_W-1:0]       src_q;
	logic                            present_q;
	logic [vic_pkg::CNT_W-1:0]       count_q;

	logic                            in_range;
	logic                            hit;
	logic                            full;
	logic                            wr_en;
	logic [AW-1:0]                   wr_addr;
	vic_pkg::vic_entry_t             wr_data;

	assign in_range = ALL_IN || (src_index < vic_pkg::IDX_W'(INDEX_COUNT));
	assign hit      = present_q && (rd_q.epoch == epoch);
	assign full     = count_q[vic_pkg::CNT_W-1];

	assign wr_en   = cmd.clear_en || (cmd.commit && present_q && !hit && !full);
	assign wr_addr = cmd.clear_en ? clear_addr : src_q[AW-1:0];
	always_comb begin
		if (cmd.clear_en) begin
			wr_data = '0;
		end else begin
			wr_data.epoch = epoch;
			wr_data.dense = count_q[vic_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (cmd.load) begin
			rd_q      <= mem_q[src_index[AW-1:0]];
			src_q     <= src_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			count_q   <= '0;
		end else begin
			if (cmd.load) present_q <= present && in_range;
			if (cmd.new_group) begin
				count_q <= '0;
			end else if (cmd.commit && present_q && !hit && !full) begin
				count_q <= count_q + vic_pkg::CNT_W'(1);
			end
		end
	end

	// An absent attribute reports all zeros; a full counter hands out the top index.
	always_comb begin
		result.first  = present_q && !hit;
		result.source = present_q ? src_q : '0;
		if (!present_q) begin
			result.dense = '0;
		end else if (hit) begin
			result.dense = rd_q.dense;
		end else if (full) begin
			result.dense = '1;
		end else begin
			result.dense = count_q[vic_pkg::IDX_W-1:0];
		end
	end

endmodule

>>> rtl/core/vic_datapath.sv
module vic_datapath #(
	parameter int INDEX_COUNT = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vic_pkg::vic_cmd_t         cmd,
	output vic_pkg::vic_stat_t        stat,
	input  logic [vic_pkg::IDX_W-1:0] position_index,
	input  logic [vic_pkg::IDX_W-1:0] normal_index,
	input  logic [vic_pkg::IDX_W-1:0] texcoord_index,
	input  logic                      has_normal,
	input  logic                      has_texcoord,
	input  logic                      out_ready,
	output logic                      out_valid,
	output vic_pkg::vic_attr_t        out_position,
	output vic_pkg::vic_attr_t        out_normal,
	output vic_pkg::vic_attr_t        out_texcoord
);

	localparam int DEPTH = (INDEX_COUNT > 4096) ? 4096 : INDEX_COUNT;
	localparam int AW    = $clog2(DEPTH);

	logic [vic_pkg::EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]               clr_q;
	logic                        out_valid_q;
	vic_pkg::vic_attr_t          pos_res, nrm_res, tex_res;
	vic_pkg::vic_attr_t          pos_q, nrm_q, tex_q;

	assign stat.epoch_last = (epoch_q == '1);
	assign stat.clear_done = cmd.clear_en && (clr_q == AW'(DEPTH - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

	// Epoch zero marks swept entries, so live groups count from one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= vic_pkg::EPOCH_W'(1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.new_group) begin
				epoch_q <= stat.epoch_last ? vic_pkg::EPOCH_W'(1)
				                           : epoch_q + vic_pkg::EPOCH_W'(1);
			end
			if (cmd.clear_en) begin
				clr_q <= stat.clear_done ? '0 : clr_q + AW'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			pos_q <= pos_res;
			nrm_q <= nrm_res;
			tex_q <= tex_res;
		end
	end

	vic_remap #(.INDEX_COUNT(INDEX_COUNT)) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.epoch      (epoch_q),
		.clear_addr (clr_q),
		.src_index  (position_index),
		.present    (1'b1),
		.result     (pos_res)
	);

	vic_remap #(.INDEX_COUNT(INDEX_COUNT)) u_nrm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.epoch      (epoch_q),
		.clear_addr (clr_q),
		.src_index  (normal_index),
		.present    (has_normal),
		.result     (nrm_res)
	);

	vic_remap #(.INDEX_COUNT(INDEX_COUNT)) u_tex (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.epoch      (epoch_q),
		.clear_addr (clr_q),
		.src_index  (texcoord_index),
		.present    (has_texcoord),
		.result     (tex_res)
	);

	assign out_valid    = out_valid_q;
	assign out_position = pos_q;
	assign out_normal   = nrm_q;
	assign out_texcoord = tex_q;

endmodule

>>> dv/vertex_index_compactor_test.sv
module vertex_index_compactor_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vic_pkg::*;

	// The block is built with its default index range, so every 12-bit index is in range.
	localparam int INDEX_LIMIT = 4096;
	localparam int MAP_SLOTS = 4096;

	// A clearing sweep after reset and on every 255th group keeps the input stalled while it
	// writes all 4096 map entries, and the receiver hold-off of HOLD_CYCLES stalls the output.
	// The limit allows for both several times over.
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 120;
	localparam int ROLLOVER_GROUPS = 270;

	// Indices that every group of the rollover test draws from, so that map entries written
	// in earlier groups are always present when the group epoch wraps.
	localparam logic [IDX_W-1:0] ROLLOVER_POOL [4] = '{12'd0, 12'd1, 12'd4094, 12'd4095};

	typedef enum int {
		ATTR_POSITION,
		ATTR_NORMAL,
		ATTR_TEXCOORD
	} attr_kind_t;

	// One remapped corner: position, normal and texcoord, indexed by attr_kind_t.
	typedef vic_attr_t [2:0] corner_remap_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             command;
	logic [IDX_W-1:0] position_index;
	logic [IDX_W-1:0] normal_index;
	logic [IDX_W-1:0] texcoord_index;
	logic             has_normal;
	logic             has_texcoord;
	logic             out_valid;
	logic             out_ready;
	logic [IDX_W-1:0] dense_position;
	logic             position_first;
	logic [IDX_W-1:0] source_position;
	logic [IDX_W-1:0] dense_normal;
	logic             normal_first;
	logic [IDX_W-1:0] source_normal;
	logic [IDX_W-1:0] dense_texcoord;
	logic             texcoord_first;
	logic [IDX_W-1:0] source_texcoord;

	vertex_index_compactor #(
		.INDEX_COUNT(INDEX_LIMIT)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.position_index (position_index),
		.normal_index   (normal_index),
		.texcoord_index (texcoord_index),
		.has_normal     (has_normal),
		.has_texcoord   (has_texcoord),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.dense_position (dense_position),
		.position_first (position_first),
		.source_position(source_position),
		.dense_normal   (dense_normal),
		.normal_first   (normal_first),
		.source_normal  (source_normal),
		.dense_texcoord (dense_texcoord),
		.texcoord_first (texcoord_first),
		.source_texcoord(source_texcoord)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Our own copy of the three maps and their counters. A slot holds the dense index that
	// its source index received in the current group; slot_used says whether it has one.
	bit          slot_used  [3][MAP_SLOTS];
	bit [11:0]   slot_dense [3][MAP_SLOTS];
	int unsigned group_count[3];

	corner_remap_t awaited_corners[$];

	int failures = 0;
	int idle_cycles = 0;
	int groups_sent = 0;
	int burst_left = 0;
	int hold_request = 0;
	bit sender_gaps = 1'b0;
	bit stall_receiver = 1'b0;

	string attr_name[3] = '{"position", "normal", "texcoord"};

	function automatic void report_failure(string msg);
		failures++;
		if (failures <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	// A start-group transfer forgets every mapping and restarts all three counters.
	function automatic void start_group_maps();
		for (int k = 0; k < 3; k++) begin
			group_count[k] = 0;
			for (int i = 0; i < MAP_SLOTS; i++) begin
				slot_used[k][i] = 1'b0;
			end
		end
	endfunction

	// Dense index, first flag and passed-through source for one attribute of a corner.
	function automatic vic_attr_t remap_attr(attr_kind_t kind, logic [IDX_W-1:0] src,
			logic present);
		vic_attr_t r;
		r = '0;
		// An absent attribute, or one out of range, reports all zeros and touches nothing.
		if (!present || int'(src) >= INDEX_LIMIT) begin
			return r;
		end
		r.source = src;
		if (slot_used[kind][src]) begin
			r.dense = slot_dense[kind][src];
			return r;
		end
		r.first = 1'b1;
		// A full map hands out the top index without storing it.
		if (group_count[kind] >= MAP_SLOTS) begin
			r.dense = '1;
			return r;
		end
		r.dense = IDX_W'(group_count[kind]);
		slot_used[kind][src] = 1'b1;
		slot_dense[kind][src] = r.dense;
		group_count[kind]++;
		return r;
	endfunction

	// Offers one item and waits for its transfer. The sender works in bursts: at the start
	// of each burst it drops valid for a random gap. in_ready is sampled on the falling
	// edge, where it already holds the value that the next rising edge will see.
	task automatic send_item(logic cmd, logic [IDX_W-1:0] pos, logic [IDX_W-1:0] nrm,
			logic [IDX_W-1:0] tex, logic hn, logic ht);
		int gap;
		bit taken;
		corner_remap_t r;
		gap = 0;
		if (sender_gaps) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= cmd;
		position_index <= pos;
		normal_index   <= nrm;
		texcoord_index <= tex;
		has_normal     <= hn;
		has_texcoord   <= ht;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		if (cmd == CMD_GROUP) begin
			groups_sent++;
			start_group_maps();
		end else begin
			r[ATTR_POSITION] = remap_attr(ATTR_POSITION, pos, 1'b1);
			r[ATTR_NORMAL]   = remap_attr(ATTR_NORMAL, nrm, hn);
			r[ATTR_TEXCOORD] = remap_attr(ATTR_TEXCOORD, tex, ht);
			awaited_corners = {awaited_corners, r};
		end
	endtask

	task automatic send_corner(logic [IDX_W-1:0] pos, logic [IDX_W-1:0] nrm,
			logic [IDX_W-1:0] tex, logic hn, logic ht);
		send_item(CMD_CORNER, pos, nrm, tex, hn, ht);
	endtask

	// The corner fields of a start-group transfer are ignored, so they carry random junk.
	task automatic send_group();
		send_item(CMD_GROUP, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
			1'($urandom), 1'($urandom));
	endtask

	// Lowers valid after the last transfer of a test and waits for a rising clock edge, so that the
	// next test never lowers and raises valid in the same time step.
	task automatic stop_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly indices from a small window, so that reuse within a group is common, and
	// now and then any index at all.
	function automatic logic [IDX_W-1:0] pick_index(logic [IDX_W-1:0] base, int span);
		if ($urandom_range(0, 9) < 7) begin
			return base + IDX_W'($urandom_range(0, span - 1));
		end
		return IDX_W'($urandom);
	endfunction

	// Extremes of every field, absent attributes, separate maps, repeated and ignored
	// group commands. The first corner runs against the maps as left by reset.
	task automatic test_directed_corners();
		sender_gaps = 1'b0;
		stall_receiver = 1'b0;
		send_corner(12'd0, 12'd0, 12'd0, 1'b1, 1'b1);
		send_corner(12'd0, 12'd0, 12'd0, 1'b1, 1'b1);
		send_corner(12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1);
		send_corner(12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1);
		// Both optional attributes absent: their result fields must read zero.
		send_corner(12'hAAA, 12'h555, 12'hFFF, 1'b0, 1'b0);
		send_corner(12'h555, 12'hAAA, 12'h555, 1'b1, 1'b0);
		send_corner(12'hAAA, 12'h555, 12'hAAA, 1'b0, 1'b1);
		// The same number in different attributes lands in different maps.
		send_corner(12'd0, 12'd4095, 12'd0, 1'b1, 1'b1);
		send_item(CMD_GROUP, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1);
		send_item(CMD_GROUP, 12'h000, 12'h000, 12'h000, 1'b0, 1'b0);
		// After the new group the old indices are first again and start from zero.
		send_corner(12'd4095, 12'd0, 12'd4095, 1'b1, 1'b1);
		send_corner(12'd0, 12'd4095, 12'd0, 1'b1, 1'b1);
		send_corner(12'd4095, 12'd0, 12'd4095, 1'b1, 1'b1);
		send_corner(12'hAAA, 12'h555, 12'hAAA, 1'b1, 1'b1);
		send_group();
		send_corner(12'hAAA, 12'h555, 12'hAAA, 1'b1, 1'b1);
		stop_input();
	endtask

	// Back-to-back corners that keep hitting the same few entries, with no idling on
	// either side, so that a lookup follows right behind the write of the same entry.
	task automatic test_hit_forwarding();
		logic [IDX_W-1:0] pos[2], nrm[2], tex[2];
		sender_gaps = 1'b0;
		stall_receiver = 1'b0;
		for (int i = 0; i < 2; i++) begin
			pos[i] = IDX_W'($urandom);
			nrm[i] = IDX_W'($urandom);
			tex[i] = IDX_W'($urandom);
		end
		send_group();
		repeat (24) begin
			send_corner(pos[$urandom_range(0, 1)], nrm[$urandom_range(0, 1)],
				tex[$urandom_range(0, 1)], 1'b1, 1'b1);
		end
		stop_input();
	endtask

	// The receiver holds off for a long stretch while corners keep coming, so that the
	// block fills up and must stall its input until the results drain.
	task automatic test_output_backpressure();
		logic [IDX_W-1:0] base;
		sender_gaps = 1'b0;
		stall_receiver = 1'b0;
		base = IDX_W'($urandom);
		send_group();
		hold_request = HOLD_CYCLES;
		repeat (40) begin
			send_corner(pick_index(base, 8), pick_index(base, 8), pick_index(base, 8),
				1'($urandom), 1'($urandom));
		end
		stop_input();
	endtask

	// Groups of random size with random content. Most groups are small; some are long
	// enough to build up a real map. Idling on both sides changes from group to group.
	task automatic test_random_groups();
		int sent, corners, span;
		logic [IDX_W-1:0] pbase, nbase, tbase, pos, nrm, tex;
		logic group_hn, group_ht, hn, ht;
		sent = 0;
		pos = '0;
		nrm = '0;
		tex = '0;
		hn = 1'b1;
		ht = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			sender_gaps = ($urandom_range(0, 3) != 0);
			stall_receiver = ($urandom_range(0, 3) != 0);
			send_group();
			sent++;
			corners = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 48) :
				$urandom_range(1, 8);
			span = $urandom_range(1, 16);
			pbase = IDX_W'($urandom);
			nbase = IDX_W'($urandom);
			tbase = IDX_W'($urandom);
			group_hn = ($urandom_range(0, 3) != 0);
			group_ht = ($urandom_range(0, 3) != 0);
			repeat (corners) begin
				// Now and then the previous corner is sent again unchanged.
				if ($urandom_range(0, 9) != 0) begin
					pos = pick_index(pbase, span);
					nrm = pick_index(nbase, span);
					tex = pick_index(tbase, span);
					hn = group_hn ^ ($urandom_range(0, 7) == 0);
					ht = group_ht ^ ($urandom_range(0, 7) == 0);
				end
				send_corner(pos, nrm, tex, hn, ht);
				sent++;
			end
		end
		stop_input();
	endtask

	// Enough short groups to pass the point where the group epoch wraps and the maps are
	// swept again. Every group reuses the same few indices, so a stale entry that survived
	// the wrap would show up as a wrong hit.
	task automatic test_group_rollover();
		while (groups_sent < ROLLOVER_GROUPS) begin
			sender_gaps = ($urandom_range(0, 1) != 0);
			stall_receiver = ($urandom_range(0, 1) != 0);
			send_group();
			send_corner(ROLLOVER_POOL[$urandom_range(0, 3)],
				ROLLOVER_POOL[$urandom_range(0, 3)],
				ROLLOVER_POOL[$urandom_range(0, 3)],
				($urandom_range(0, 7) != 0), ($urandom_range(0, 7) != 0));
		end
		stop_input();
	endtask

	// The receiver. With stall_receiver set, ready follows a 16-bit pattern that is drawn again
	// once all its bits are used, a quarter of the patterns being all ones; else ready is high. A
	// hold-off request takes precedence and keeps ready low for the requested number of cycles.
	initial begin : result_sink
		int hold;
		int phase;
		bit [15:0] pattern;
		phase = 0;
		pattern = '1;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else begin
				if (phase == 0) begin
					pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
				end
				out_ready <= !stall_receiver || pattern[phase];
				phase = (phase + 1) % 16;
			end
		end
	end

	// Each result transfer is checked field by field against the oldest awaited corner.
	// Outputs are sampled on the falling edge, away from the edge where they change.
	always @(negedge clk) begin : result_check
		corner_remap_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got[ATTR_POSITION] = {dense_position, position_first, source_position};
			got[ATTR_NORMAL]   = {dense_normal, normal_first, source_normal};
			got[ATTR_TEXCOORD] = {dense_texcoord, texcoord_first, source_texcoord};
			if (awaited_corners.size() == 0) begin
				report_failure("result transfer with no corner awaiting it");
			end else begin
				want = awaited_corners.pop_front();
				for (int k = 0; k < 3; k++) begin
					if (got[k].dense !== want[k].dense) begin
						report_failure($sformatf("dense_%s: expected %0d, got %0d",
							attr_name[k], want[k].dense, got[k].dense));
					end
					if (got[k].first !== want[k].first) begin
						report_failure($sformatf("%s_first: expected %0d, got %0d",
							attr_name[k], want[k].first, got[k].first));
					end
					if (got[k].source !== want[k].source) begin
						report_failure($sformatf("source_%s: expected %0d, got %0d",
							attr_name[k], want[k].source, got[k].source));
					end
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel completes a transfer.
	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		command        <= CMD_GROUP;
		position_index <= '0;
		normal_index   <= '0;
		texcoord_index <= '0;
		has_normal     <= 1'b0;
		has_texcoord   <= 1'b0;
		start_group_maps();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_hit_forwarding();
		test_output_backpressure();
		test_random_groups();
		test_group_rollover();

		// A lost result leaves the queue non-empty forever; the watchdog ends that case.
		while (awaited_corners.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
